// ----- hdl/owtc_pkg.sv -----
// shared types, constants and crc function for the scratchpad temperature checker
package owtc_pkg;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// reflected 1-wire crc8 polynomial
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// low bit of the crc feedback test
	localparam logic [7:0] CRC_LSB_MASK = 8'h01;

	// error value, -273 degrees in 1/16 degree units, and its whole-degree form
	localparam logic signed [15:0] ERR_RAW   = -16'sd4368;
	localparam logic signed [11:0] ERR_WHOLE = -12'sd273;

	// rounding term added before the divide by 16
	localparam logic signed [16:0] ROUND_ADD = 17'sh0000F;

	// largest whole-degree value
	localparam logic signed [12:0] WHOLE_MAX = 13'sd2047;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_PRESENCE = 2'd1,
		ST_CRC_ERROR   = 2'd2
	} status_t;

	// one byte of crc8, bit by bit, lsb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b_in);
		logic [7:0] crc;
		logic [7:0] b;
		logic       fb;
		crc = crc_in;
		b   = b_in;
		for (int i = 0; i < 8; i++) begin
			fb  = |((crc ^ b) & CRC_LSB_MASK);
			crc = crc >> 1;
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return crc;
	endfunction

	// floor((raw + 15) / 16), saturated at the top
	function automatic logic signed [11:0] whole_of(input logic signed [15:0] raw);
		logic signed [16:0] sum;
		logic signed [12:0] w;
		sum = {raw[15], raw} + ROUND_ADD;
		w   = sum[16:4];
		if (w > WHOLE_MAX) begin
			w = WHOLE_MAX;
		end
		return w[11:0];
	endfunction

endpackage

// ----- hdl/onewire_scratchpad_temp_checker_top.sv -----
// scratchpad frame checker: crc8 over the scratchpad and temperature result
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_stall  | command, presence, data_byte
//  out     | out_valid | out_stall | temp_fixed, whole_degrees, status
//
// One item per cycle while the output is not stalled: an item is held in the input
// register, then the byte-wide crc update and result logic load the state and the output register.
// A result passes from the input register into the output register and is held there until it is taken.
// Reset clears the frame state and both valid flags; no frame is open after it.
// A stall on the output holds the output register and the input register and
// raises in_stall once the input register is full.
module onewire_scratchpad_temp_checker_top #(
	parameter int SCRATCHPAD_BYTES = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     command,
	input  logic                     presence,
	input  logic [7:0]               data_byte,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       temp_fixed,
	output logic signed [11:0]       whole_degrees,
	output owtc_pkg::status_t        status
);
	import owtc_pkg::*;

	localparam int CNT_W = $clog2(SCRATCHPAD_BYTES);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SCRATCHPAD_BYTES - 1);
	localparam logic [CNT_W-1:0] IDX_LOW  = CNT_W'(0);
	localparam logic [CNT_W-1:0] IDX_HIGH = CNT_W'(1);

	// input register
	logic             valid_s1;
	logic             command_s1;
	logic             presence_s1;
	logic [7:0]       data_s1;

	// frame state
	logic [7:0]       crc_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       temp_low_q;
	logic [7:0]       temp_high_q;
	logic             frame_active_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] temp_fixed_q;
	logic signed [11:0] whole_q;
	status_t            status_q;

	logic advance;
	logic load_s1;

	// next-state and result logic
	logic [7:0]         crc_d;
	logic [CNT_W-1:0]   byte_count_d;
	logic [7:0]         temp_low_d;
	logic [7:0]         temp_high_d;
	logic               frame_active_d;
	logic               res_valid;
	logic signed [15:0] res_raw;
	logic signed [11:0] res_whole;
	status_t            res_status;
	logic signed [15:0] stored_raw;

	// handshake: the stage moves when the output register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	assign stored_raw = $signed({temp_high_q, temp_low_q});

	// frame sequencing on the item in the input register
	always_comb begin
		crc_d          = crc_q;
		byte_count_d   = byte_count_q;
		temp_low_d     = temp_low_q;
		temp_high_d    = temp_high_q;
		frame_active_d = frame_active_q;
		res_valid      = 1'b0;
		res_raw        = ERR_RAW;
		res_whole      = ERR_WHOLE;
		res_status     = ST_OK;
		if (command_s1 == CMD_START) begin
			crc_d        = '0;
			byte_count_d = '0;
			if (!presence_s1) begin
				frame_active_d = 1'b0;
				res_valid      = 1'b1;
				res_status     = ST_NO_PRESENCE;
			end else begin
				frame_active_d = 1'b1;
			end
		end else if (frame_active_q) begin
			if (byte_count_q >= LAST_IDX) begin
				frame_active_d = 1'b0;
				byte_count_d   = '0;
				res_valid      = 1'b1;
				if (data_s1 != crc_q) begin
					res_status = ST_CRC_ERROR;
				end else begin
					res_raw   = stored_raw;
					res_whole = whole_of(stored_raw);
				end
			end else begin
				if (byte_count_q == IDX_LOW) begin
					temp_low_d = data_s1;
				end else if (byte_count_q == IDX_HIGH) begin
					temp_high_d = data_s1;
				end
				crc_d        = crc8_byte(crc_q, data_s1);
				byte_count_d = byte_count_q + CNT_W'(1);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			crc_q          <= '0;
			byte_count_q   <= '0;
			temp_low_q     <= '0;
			temp_high_q    <= '0;
			frame_active_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res_valid;
				if (valid_s1) begin
					crc_q          <= crc_d;
					byte_count_q   <= byte_count_d;
					temp_low_q     <= temp_low_d;
					temp_high_q    <= temp_high_d;
					frame_active_q <= frame_active_d;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			command_s1  <= command;
			presence_s1 <= presence;
			data_s1     <= data_byte;
		end
		if (advance && valid_s1 && res_valid) begin
			temp_fixed_q <= res_raw;
			whole_q      <= res_whole;
			status_q     <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign temp_fixed    = temp_fixed_q;
	assign whole_degrees = whole_q;
	assign status        = status_q;

	// checks
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |->
			(temp_fixed_q == ERR_RAW) && (whole_q == ERR_WHOLE))
		else $error("error result without error value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= LAST_IDX)
		else $error("byte count past last scratchpad byte");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_active_q |-> byte_count_q == '0)
		else $error("byte count nonzero with no frame open");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && res_valid |=> !frame_active_q)
		else $error("frame still open after a result");

endmodule
